// ===== rtl/ssa_pkg.sv =====
`default_nettype none

package ssa_pkg;

	localparam int ID_W     = 8;
	localparam int ADDR_W   = 48;
	localparam int TIME_W   = 32;
	localparam int TMO_W    = 16;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;

	localparam int DEF_MAX_SESSIONS = 16;

	localparam logic [TMO_W-1:0] TMO_RESET = 16'd60;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_OPEN   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BUSY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] owner;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	// table memory access; indexes are zero based (id - 1)
	typedef struct packed {
		logic            we;
		logic [ID_W-1:0] widx;
		entry_t          wdata;
		logic [ID_W-1:0] ridx;
	} mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/ssa_if.sv =====
`default_nettype none

interface ssa_req_if;
	logic                         valid;
	logic                         ready;
	logic [ssa_pkg::KIND_W-1:0]   kind;
	logic [ssa_pkg::ADDR_W-1:0]   client_addr;
	logic                         client_active;
	logic [ssa_pkg::ID_W-1:0]     session_id;
	logic [ssa_pkg::TIME_W-1:0]   now_time;

	modport source(output valid, kind, client_addr, client_active, session_id, now_time,
		input ready);
	modport sink(input valid, kind, client_addr, client_active, session_id, now_time,
		output ready);
endinterface

interface ssa_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ssa_pkg::STATUS_W-1:0] status;
	logic [ssa_pkg::ID_W-1:0]     assigned_id;
	logic                         slot_was_open;

	modport source(output valid, status, assigned_id, slot_was_open, input ready);
	modport sink(input valid, status, assigned_id, slot_was_open, output ready);
endinterface

`default_nettype wire

// ===== rtl/ssa_slot_mem.sv =====
`default_nettype none

module ssa_slot_mem #(
	parameter int MAX_SESSIONS = ssa_pkg::DEF_MAX_SESSIONS
) (
	input  wire logic              clk,
	input  wire ssa_pkg::mem_req_t mem_req,
	output ssa_pkg::entry_t        rdata
);

	localparam int AW = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;

	ssa_pkg::entry_t mem [MAX_SESSIONS];
	ssa_pkg::entry_t rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem[mem_req.widx[AW-1:0]] <= mem_req.wdata;
		end
		rdata_q <= mem[mem_req.ridx[AW-1:0]];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/ssa_ctrl.sv =====
`default_nettype none

module ssa_ctrl #(
	parameter int MAX_SESSIONS = ssa_pkg::DEF_MAX_SESSIONS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	ssa_req_if.sink                        req,
	ssa_rsp_if.source                      rsp,
	input  wire logic                      cfg_wr_en,
	input  wire logic [ssa_pkg::TMO_W-1:0] cfg_wr_data,
	output ssa_pkg::mem_req_t              mem_req,
	input  wire ssa_pkg::entry_t           mem_rdata
);

	localparam int ID_W = ssa_pkg::ID_W;
	localparam int SW   = $clog2(MAX_SESSIONS + 1);
	localparam int AW   = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;

	localparam logic [SW-1:0]   S_MAX  = SW'(MAX_SESSIONS);
	localparam logic [SW-1:0]   S_ONE  = SW'(1);
	localparam logic [ID_W-1:0] ID_MAX = ID_W'(MAX_SESSIONS);
	localparam logic [ID_W-1:0] ID_ONE = ID_W'(1);

	typedef enum logic [1:0] {S_IDLE, S_CHECK, S_SCAN, S_DONE} state_t;

	state_t                          state_q;
	logic [ssa_pkg::TMO_W-1:0]       tmo_q;
	logic [MAX_SESSIONS-1:0]         valid_q;
	logic [SW-1:0]                   next_q;

	logic [ssa_pkg::KIND_W-1:0]      kind_q;
	logic [ssa_pkg::ADDR_W-1:0]      addr_q;
	logic [ID_W-1:0]                 sid_q;
	logic [ssa_pkg::TIME_W-1:0]      now_q;

	logic [SW-1:0]                   ptr_q;
	logic [SW-1:0]                   iss_q;
	logic                            v_s1;
	logic                            free_s1;
	logic [SW-1:0]                   slot_s1;
	logic [SW-1:0]                   best_q;
	logic [ssa_pkg::TIME_W-1:0]      best_idle_q;

	logic [ssa_pkg::STATUS_W-1:0]    res_status_q;
	logic [ID_W-1:0]                 res_id_q;
	logic                            res_open_q;

	logic                            rsp_valid_q;
	logic [ssa_pkg::STATUS_W-1:0]    rsp_status_q;
	logic [ID_W-1:0]                 rsp_id_q;
	logic                            rsp_open_q;

	logic [ID_W-1:0]                 in_idx;
	logic                            in_rng;
	logic                            in_vld;
	logic [ID_W-1:0]                 sid_idx;
	logic [SW-1:0]                   ptr_idx;
	logic [SW-1:0]                   s1_idx;
	logic [SW-1:0]                   best_idx;
	logic [SW-1:0]                   ptr_nxt;
	logic [SW-1:0]                   s1_nxt;
	logic [ssa_pkg::TIME_W-1:0]      idle;
	logic                            owner_ok;
	logic                            scan_end;

	always_comb begin
		in_idx   = req.session_id - ID_ONE;
		in_rng   = (req.session_id != '0) && (req.session_id <= ID_MAX);
		in_vld   = in_rng && valid_q[in_idx[AW-1:0]];
		sid_idx  = sid_q - ID_ONE;
		ptr_idx  = ptr_q - S_ONE;
		s1_idx   = slot_s1 - S_ONE;
		best_idx = best_q - S_ONE;
		ptr_nxt  = (ptr_q == S_MAX) ? S_ONE : ptr_q + S_ONE;
		s1_nxt   = (slot_s1 == S_MAX) ? S_ONE : slot_s1 + S_ONE;
		idle     = now_q - mem_rdata.stamp;
		owner_ok = (mem_rdata.owner == addr_q);
		scan_end = !v_s1 && (iss_q == S_MAX);
	end

	// table memory port
	always_comb begin
		mem_req       = '0;
		mem_req.wdata = '{owner: addr_q, stamp: now_q};
		unique case (state_q)
			S_IDLE: begin
				mem_req.ridx  = in_idx;
				mem_req.wdata = '{owner: req.client_addr, stamp: req.now_time};
				if (req.valid && req.kind == ssa_pkg::KIND_OPEN && req.client_active && in_rng) begin
					mem_req.we   = 1'b1;
					mem_req.widx = in_idx;
				end
			end
			S_CHECK: begin
				mem_req.we   = owner_ok;
				mem_req.widx = sid_idx;
			end
			S_SCAN: begin
				mem_req.ridx = ID_W'(ptr_idx);
				if (v_s1 && free_s1) begin
					mem_req.we   = 1'b1;
					mem_req.widx = ID_W'(s1_idx);
				end else if (scan_end && best_q != '0) begin
					mem_req.we   = 1'b1;
					mem_req.widx = ID_W'(best_idx);
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.assigned_id   = rsp_id_q;
	assign rsp.slot_was_open = rsp_open_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			tmo_q        <= ssa_pkg::TMO_RESET;
			valid_q      <= '0;
			next_q       <= S_ONE;
			kind_q       <= '0;
			addr_q       <= '0;
			sid_q        <= '0;
			now_q        <= '0;
			ptr_q        <= S_ONE;
			iss_q        <= '0;
			v_s1         <= 1'b0;
			free_s1      <= 1'b0;
			slot_s1      <= S_ONE;
			best_q       <= '0;
			best_idle_q  <= '0;
			res_status_q <= ssa_pkg::ST_BAD;
			res_id_q     <= '0;
			res_open_q   <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ssa_pkg::ST_BAD;
			rsp_id_q     <= '0;
			rsp_open_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				tmo_q <= cfg_wr_data;
			end
			// in S_DONE the reload below decides rsp_valid_q
			if (rsp.valid && rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					v_s1 <= 1'b0;
					if (req.valid) begin
						kind_q       <= req.kind;
						addr_q       <= req.client_addr;
						sid_q        <= req.session_id;
						now_q        <= req.now_time;
						res_status_q <= ssa_pkg::ST_BAD;
						res_id_q     <= '0;
						res_open_q   <= 1'b0;
						state_q      <= S_DONE;
						if (req.kind == ssa_pkg::KIND_OPEN) begin
							if (req.client_active) begin
								if (in_rng) begin
									valid_q[in_idx[AW-1:0]] <= 1'b1;
									res_status_q <= ssa_pkg::ST_OK;
									res_id_q     <= req.session_id;
									res_open_q   <= in_vld;
								end
							end else begin
								ptr_q       <= next_q;
								iss_q       <= '0;
								best_q      <= '0;
								best_idle_q <= ssa_pkg::TIME_W'(tmo_q);
								state_q     <= S_SCAN;
							end
						end else if (req.kind == ssa_pkg::KIND_UPDATE ||
								req.kind == ssa_pkg::KIND_CLOSE) begin
							res_id_q <= req.session_id;
							if (in_vld) begin
								state_q <= S_CHECK;
							end
						end
					end
				end
				S_CHECK: begin
					if (owner_ok) begin
						res_status_q <= ssa_pkg::ST_OK;
						if (kind_q == ssa_pkg::KIND_CLOSE) begin
							valid_q[sid_idx[AW-1:0]] <= 1'b0;
						end
					end
					state_q <= S_DONE;
				end
				S_SCAN: begin
					// issue: one slot read per cycle
					if (iss_q != S_MAX) begin
						v_s1    <= 1'b1;
						slot_s1 <= ptr_q;
						free_s1 <= !valid_q[ptr_idx[AW-1:0]];
						ptr_q   <= ptr_nxt;
						iss_q   <= iss_q + S_ONE;
					end else begin
						v_s1 <= 1'b0;
					end
					// evaluate the slot read last cycle
					if (v_s1) begin
						if (free_s1) begin
							valid_q[s1_idx[AW-1:0]] <= 1'b1;
							next_q       <= s1_nxt;
							res_status_q <= ssa_pkg::ST_OK;
							res_id_q     <= ID_W'(slot_s1);
							state_q      <= S_DONE;
						end else if (idle > best_idle_q) begin
							best_idle_q <= idle;
							best_q      <= slot_s1;
						end
					end else if (scan_end) begin
						if (best_q != '0) begin
							res_status_q <= ssa_pkg::ST_OK;
							res_id_q     <= ID_W'(best_q);
							res_open_q   <= 1'b1;
						end else begin
							res_status_q <= ssa_pkg::ST_BUSY;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_id_q     <= res_id_q;
						rsp_open_q   <= res_open_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/session_slot_allocator.sv =====
// Channel   Dir   Beat contents
// req       in    kind, client_addr, client_active, session_id, now_time
// rsp       out   status, assigned_id, slot_was_open
// cfg_wr_*  in    idle_timeout (16 bit), written whenever cfg_wr_en is high
//
// One request is worked at a time; req.ready is high only while the block is idle.
// Steps below run from one accept to the earliest next accept; rsp.valid is set as
// req.ready returns. Open by a new client: the scan reads one slot per cycle through
// the registered table read port, then settles reclaim or busy, then loads the rsp
// register. A free slot at scan position k ends the scan once its read is evaluated.
// Update and close: one table read, then write-back. Others: rsp register load only.
// A finished beat sits in the rsp register; the next request is taken while it waits,
// and its own result then stalls until the rsp register empties.
// Reset (arst_n low) frees all slots at once; no clearing pass is needed.
`default_nettype none

module session_slot_allocator #(
	parameter int MAX_SESSIONS = ssa_pkg::DEF_MAX_SESSIONS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	ssa_req_if.sink                        req,
	ssa_rsp_if.source                      rsp,
	input  wire logic                      cfg_wr_en,
	input  wire logic [ssa_pkg::TMO_W-1:0] cfg_wr_data
);

	// ctrl <-> slot table: owner address and last-activity stamp per slot
	ssa_pkg::mem_req_t mem_req;
	ssa_pkg::entry_t   mem_rdata;

	// sequencer: valid bits, round-robin pointer, scan, response register
	ssa_ctrl #(
		.MAX_SESSIONS(MAX_SESSIONS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.mem_req    (mem_req),
		.mem_rdata  (mem_rdata)
	);

	// slot table, registered read
	ssa_slot_mem #(
		.MAX_SESSIONS(MAX_SESSIONS)
	) u_slot_mem (
		.clk    (clk),
		.mem_req(mem_req),
		.rdata  (mem_rdata)
	);

endmodule

`default_nettype wire

// ===== rtl/ssa_checker.sv =====
`default_nettype none

module ssa_checker #(
	parameter int MAX_SESSIONS = ssa_pkg::DEF_MAX_SESSIONS
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         req_valid,
	input wire logic                         req_ready,
	input wire logic                         rsp_valid,
	input wire logic                         rsp_ready,
	input wire logic [ssa_pkg::STATUS_W-1:0] rsp_status,
	input wire logic [ssa_pkg::ID_W-1:0]     rsp_assigned_id,
	input wire logic                         rsp_slot_was_open
);

	localparam logic [ssa_pkg::ID_W-1:0] ID_MAX = ssa_pkg::ID_W'(MAX_SESSIONS);

	// held beat must not drop
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp beat dropped while stalled");

	// one request in flight: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while one is in work");

	// granted id is a real slot
	a_ok_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ssa_pkg::ST_OK |->
			rsp_assigned_id != '0 && rsp_assigned_id <= ID_MAX)
		else $error("ok response with out-of-range id");

	// busy carries no id and no reclaim
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ssa_pkg::ST_BUSY |->
			rsp_assigned_id == '0 && !rsp_slot_was_open)
		else $error("busy response with id or reclaim flag");

	// reclaim flag only on success
	a_open_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_slot_was_open |-> rsp_status == ssa_pkg::ST_OK)
		else $error("slot_was_open on failed request");

endmodule

bind session_slot_allocator ssa_checker #(
	.MAX_SESSIONS(MAX_SESSIONS)
) u_ssa_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_assigned_id  (rsp.assigned_id),
	.rsp_slot_was_open(rsp.slot_was_open)
);

`default_nettype wire

// ===== bench/tb_session_slot_allocator.sv =====
`timescale 1ns / 1ps

module tb_session_slot_allocator;
	import ssa_pkg::*;

	localparam int NSLOT = DEF_MAX_SESSIONS;
	localparam logic [KIND_W-1:0] KIND_BOGUS = 2'd3;	// the one undefined request code
	localparam int RANDOM_PER_PHASE = 200;
	localparam int NUM_PHASES = 6;
	localparam int DRAIN_CYCLES = NSLOT + 8;	// covers the longest request, a full-table open scan

	// one request beat
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] addr;
		logic              active;
		logic [ID_W-1:0]   sid;
		logic [TIME_W-1:0] now;
	} sess_req_t;

	// one response beat
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     id;
		logic                was_open;
	} sess_rsp_t;

	// full allocator state; ids index the arrays directly (1..NSLOT)
	typedef struct packed {
		logic [NSLOT:1]             live;
		logic [NSLOT:1][ADDR_W-1:0] owner;
		logic [NSLOT:1][TIME_W-1:0] stamp;
		logic [ID_W-1:0]            rr_next;
		logic [TMO_W-1:0]           timeout;
	} slot_table_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [TMO_W-1:0] cfg_wr_data;

	ssa_req_if req_ch ();
	ssa_rsp_if rsp_ch ();

	session_slot_allocator #(
		.MAX_SESSIONS(NSLOT)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Two copies of the table: plan_tbl runs ahead at generation time so the
	// stimulus can target live sessions; grant_tbl advances only on accepted
	// beats and produces the expected responses.
	slot_table_t plan_tbl;
	slot_table_t grant_tbl;

	sess_req_t pending_reqs[$];
	sess_rsp_t awaited_rsps[$];

	int n_queued;
	int n_checked;
	int n_err;
	int n_ok, n_reuse, n_busy, n_reject;
	int n_settings;
	logic no_stall;
	logic [TIME_W-1:0] plan_now;
	logic [ADDR_W-1:0] client_pool[24];

	// driver / monitor scratch
	sess_req_t on_wire;
	sess_rsp_t seen_rsp;
	sess_rsp_t want_rsp;
	logic hold_beat, load_beat, sink_rdy;
	int src_wait, src_quiet, snk_wait, snk_quiet;

	function automatic slot_table_t empty_table();
		slot_table_t t;
		t = '0;
		t.rr_next = ID_W'(1);
		t.timeout = TMO_RESET;
		return t;
	endfunction

	// Applies one request to a table and returns the response it earns.
	function automatic sess_rsp_t serve_request(inout slot_table_t t, input sess_req_t r);
		sess_rsp_t o;
		int s;
		int pick;
		logic placed;
		logic [TIME_W-1:0] top_idle;
		logic [TIME_W-1:0] age;
		o.status = ST_BAD;
		o.id = '0;
		o.was_open = 1'b0;
		case (r.kind)
			KIND_OPEN: begin
				if (r.active) begin
					// client claims to already hold r.sid: rewrite that slot blindly
					if (r.sid >= 1 && r.sid <= NSLOT) begin
						o.was_open = t.live[r.sid];
						t.live[r.sid] = 1'b1;
						t.owner[r.sid] = r.addr;
						t.stamp[r.sid] = r.now;
						o.status = ST_OK;
						o.id = r.sid;
					end
				end else begin
					// round-robin for a free slot, tracking the stalest reclaim candidate
					pick = 0;
					placed = 1'b0;
					top_idle = TIME_W'(t.timeout);
					s = int'(t.rr_next);
					if (s < 1 || s > NSLOT)
						s = 1;
					for (int i = 0; i < NSLOT && !placed; i++) begin
						if (!t.live[s]) begin
							t.live[s] = 1'b1;
							t.owner[s] = r.addr;
							t.stamp[s] = r.now;
							t.rr_next = ID_W'((s >= NSLOT) ? 1 : s + 1);
							o.status = ST_OK;
							o.id = ID_W'(s);
							placed = 1'b1;
						end else begin
							age = r.now - t.stamp[s];
							// strict compare: first in scan order wins a tie
							if (age > top_idle) begin
								top_idle = age;
								pick = s;
							end
							s = (s >= NSLOT) ? 1 : s + 1;
						end
					end
					if (!placed) begin
						if (pick != 0) begin
							// reclaim; pointer stays put
							t.owner[pick] = r.addr;
							t.stamp[pick] = r.now;
							o.status = ST_OK;
							o.id = ID_W'(pick);
							o.was_open = 1'b1;
						end else begin
							o.status = ST_BUSY;
						end
					end
				end
			end
			KIND_UPDATE, KIND_CLOSE: begin
				o.id = r.sid;
				if (r.sid >= 1 && r.sid <= NSLOT && t.live[r.sid] && t.owner[r.sid] == r.addr) begin
					t.stamp[r.sid] = r.now;
					if (r.kind == KIND_CLOSE)
						t.live[r.sid] = 1'b0;
					o.status = ST_OK;
				end
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;	// X -> 0 fires the async reset branches at time zero
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Hard stop in case the pipe locks up
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------
	// Request driver: pops pending beats, holds each until accepted, and
	// inserts random bubbles between beats.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.kind <= KIND_OPEN;
			req_ch.client_addr <= '0;
			req_ch.client_active <= 1'b0;
			req_ch.session_id <= '0;
			req_ch.now_time <= '0;
			src_wait = 0;
			src_quiet = 0;
		end else begin
			hold_beat = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				// beat taken: predict now, against the state as of this beat
				awaited_rsps.push_back(serve_request(grant_tbl, on_wire));
				hold_beat = 1'b0;
			end
			load_beat = 1'b0;
			if (!hold_beat && pending_reqs.size() > 0) begin
				if (src_wait > 0) begin
					src_wait--;
				end else if (!no_stall && src_quiet == 0 && $urandom_range(0, 7) == 0) begin
					src_wait = $urandom_range(0, 8);	// this cycle counts as the first bubble
				end else begin
					if (src_quiet > 0)
						src_quiet--;
					else if ($urandom_range(0, 31) == 0)
						src_quiet = $urandom_range(10, 40);
					on_wire = pending_reqs.pop_front();
					load_beat = 1'b1;
				end
			end
			req_ch.valid <= hold_beat | load_beat;
			if (load_beat) begin
				req_ch.kind <= on_wire.kind;
				req_ch.client_addr <= on_wire.addr;
				req_ch.client_active <= on_wire.active;
				req_ch.session_id <= on_wire.sid;
				req_ch.now_time <= on_wire.now;
			end
		end
	end

	// ------------------------------------------------------------------
	// Response monitor: random backpressure, in-order compare.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			snk_wait = 0;
			snk_quiet = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen_rsp.status = rsp_ch.status;
				seen_rsp.id = rsp_ch.assigned_id;
				seen_rsp.was_open = rsp_ch.slot_was_open;
				n_checked++;
				if (awaited_rsps.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("%0t: response with none outstanding: status=%0d id=%0d was_open=%0b",
							$realtime, seen_rsp.status, seen_rsp.id, seen_rsp.was_open);
				end else begin
					want_rsp = awaited_rsps.pop_front();
					if (seen_rsp.status !== want_rsp.status || seen_rsp.id !== want_rsp.id
							|| seen_rsp.was_open !== want_rsp.was_open) begin
						n_err++;
						if (n_err <= 10) begin
							$write("%0t: rsp #%0d expected status=%0d id=%0d was_open=%0b, ",
								$realtime, n_checked, want_rsp.status, want_rsp.id,
								want_rsp.was_open);
							$display("got status=%0d id=%0d was_open=%0b",
								seen_rsp.status, seen_rsp.id, seen_rsp.was_open);
						end
					end
				end
				if (seen_rsp.status == ST_BUSY)
					n_busy++;
				else if (seen_rsp.status == ST_OK && seen_rsp.was_open)
					n_reuse++;
				else if (seen_rsp.status == ST_OK)
					n_ok++;
				else
					n_reject++;
			end
			sink_rdy = 1'b1;
			if (snk_wait > 0) begin
				snk_wait--;
				sink_rdy = 1'b0;
			end else if (!no_stall && snk_quiet == 0 && $urandom_range(0, 7) == 0) begin
				snk_wait = $urandom_range(0, 8);
				sink_rdy = 1'b0;
			end else if (snk_quiet > 0) begin
				snk_quiet--;
			end else if ($urandom_range(0, 31) == 0) begin
				snk_quiet = $urandom_range(10, 40);
			end
			rsp_ch.ready <= sink_rdy;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic add_req(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
			input logic active, input logic [ID_W-1:0] sid, input logic [TIME_W-1:0] now);
		sess_req_t r;
		r.kind = kind;
		r.addr = addr;
		r.active = active;
		r.sid = sid;
		r.now = now;
		void'(serve_request(plan_tbl, r));
		pending_reqs.push_back(r);
		n_queued++;
	endtask

	function automatic logic [ADDR_W-1:0] rand_addr();
		return ADDR_W'({$urandom(), $urandom()});
	endfunction

	// random live slot in the planning table, 0 if the table is empty
	function automatic int live_slot();
		int hits[$];
		for (int s = 1; s <= NSLOT; s++)
			if (plan_tbl.live[s])
				hits.push_back(s);
		if (hits.size() == 0)
			return 0;
		return hits[$urandom_range(0, hits.size() - 1)];
	endfunction

	task automatic add_random_req();
		int roll;
		int s;
		logic [KIND_W-1:0] k;
		roll = $urandom_range(0, 99);
		// keep time mostly creeping forward, scaled to the current timeout
		plan_now = plan_now + $urandom_range(0, int'(plan_tbl.timeout) / 6 + 4);
		s = live_slot();
		k = $urandom_range(0, 1) ? KIND_UPDATE : KIND_CLOSE;
		if (roll < 40 || (roll < 80 && s == 0)) begin
			// new client open; sid is don't-care here, so randomize it
			add_req(KIND_OPEN, client_pool[$urandom_range(0, 23)], 1'b0,
				ID_W'($urandom_range(0, 255)), plan_now);
		end else if (roll < 52) begin
			add_req(KIND_OPEN, $urandom_range(0, 3) == 0 ? rand_addr() : plan_tbl.owner[s],
				1'b1, ID_W'(s), plan_now);
		end else if (roll < 70) begin
			add_req(KIND_UPDATE, plan_tbl.owner[s], 1'b0, ID_W'(s), plan_now);
		end else if (roll < 80) begin
			add_req(KIND_CLOSE, plan_tbl.owner[s], 1'b0, ID_W'(s), plan_now);
		end else if (roll < 92) begin
			// broken keepalive/close: wrong owner, dead slot, or id out of range
			case ($urandom_range(0, 2))
				0: add_req(k, rand_addr(), $urandom_range(0, 1),
					ID_W'(s == 0 ? $urandom_range(1, NSLOT) : s), plan_now);
				1: add_req(k, client_pool[$urandom_range(0, 23)], 1'b0,
					ID_W'($urandom_range(1, NSLOT)), plan_now);
				default: add_req(k, client_pool[$urandom_range(0, 23)], 1'b0,
					$urandom_range(0, 1) ? ID_W'(0) : ID_W'($urandom_range(NSLOT + 1, 255)),
					plan_now);
			endcase
		end else begin
			// noise: any code, any field value, sometimes a time jump
			if ($urandom_range(0, 3) == 0)
				plan_now = $urandom();
			add_req(KIND_W'($urandom_range(0, 3)), rand_addr(), $urandom_range(0, 1),
				ID_W'($urandom_range(0, 255)), plan_now);
		end
	endtask

	task automatic add_directed_reqs();
		logic [ADDR_W-1:0] zero_a;
		logic [ADDR_W-1:0] ones_a;
		zero_a = '0;
		ones_a = '1;
		add_req(KIND_OPEN, zero_a, 1'b0, ID_W'(0), '0);			// first grant, id 1
		add_req(KIND_OPEN, ones_a, 1'b0, '1, '0);			// id 2, same stamp
		add_req(KIND_UPDATE, zero_a, 1'b0, ID_W'(1), TIME_W'(5));	// good keepalive
		add_req(KIND_UPDATE, client_pool[2], 1'b0, ID_W'(2), TIME_W'(6));	// wrong owner
		add_req(KIND_CLOSE, ones_a, 1'b0, ID_W'(2), TIME_W'(7));	// good close
		add_req(KIND_CLOSE, ones_a, 1'b0, ID_W'(2), TIME_W'(8));	// already closed
		add_req(KIND_UPDATE, zero_a, 1'b0, ID_W'(0), TIME_W'(9));	// id zero
		add_req(KIND_CLOSE, zero_a, 1'b0, '1, TIME_W'(9));		// id 255
		add_req(KIND_UPDATE, zero_a, 1'b0, ID_W'(NSLOT + 1), TIME_W'(9));	// just past the table
		add_req(KIND_OPEN, zero_a, 1'b1, ID_W'(0), TIME_W'(10));	// active, id zero
		add_req(KIND_OPEN, zero_a, 1'b1, ID_W'(NSLOT + 1), TIME_W'(10));
		add_req(KIND_OPEN, zero_a, 1'b1, '1, TIME_W'(10));
		add_req(KIND_OPEN, client_pool[3], 1'b1, ID_W'(NSLOT), TIME_W'(11));	// free slot rewrite
		add_req(KIND_OPEN, client_pool[2], 1'b1, ID_W'(1), TIME_W'(12));	// other owner's slot
		add_req(KIND_BOGUS, zero_a, 1'b0, ID_W'(1), TIME_W'(13));
		add_req(KIND_OPEN, ones_a, 1'b0, ID_W'(0), '1);			// stamp of all ones
		add_req(KIND_UPDATE, ones_a, 1'b1, ID_W'(3), '0);		// wrapped clock keepalive
		plan_now = TIME_W'(20);
	endtask

	task automatic drain();
		wait (n_checked == n_queued);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_timeout(input logic [TMO_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		plan_tbl.timeout = v;
		grant_tbl.timeout = v;
		n_settings++;
	endtask

	initial begin
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		no_stall = 1'b0;
		n_queued = 0;
		n_checked = 0;
		n_err = 0;
		n_ok = 0;
		n_reuse = 0;
		n_busy = 0;
		n_reject = 0;
		n_settings = 1;
		plan_now = '0;
		plan_tbl = empty_table();
		grant_tbl = empty_table();
		client_pool[0] = '0;
		client_pool[1] = '1;
		for (int i = 2; i < 24; i++)
			client_pool[i] = rand_addr();

		for (int p = 0; p < NUM_PHASES; p++) begin
			// phase 0 runs on the reset timeout; the rest write it while idle
			case (p)
				0: add_directed_reqs();
				1: begin
					drain();
					set_timeout('0);	// any idle slot reclaimable; ties likely
				end
				2: begin
					drain();
					set_timeout('1);	// reclaim needs huge idle times
				end
				3: begin
					drain();
					set_timeout(TMO_W'(1));
					plan_now = 32'hFFFF_FF00;	// roll the clock over mid-phase
				end
				4: begin
					drain();
					set_timeout(TMO_W'($urandom_range(2, 65534)));
				end
				default: begin
					drain();
					set_timeout(TMO_W'(300));
					no_stall = 1'b1;	// closing stretch at full rate
				end
			endcase
			repeat (RANDOM_PER_PHASE) add_random_req();
		end

		drain();
		if (awaited_rsps.size() != 0)
			n_err++;
		$display("Checked %0d responses over %0d timeout settings, %0d errors.",
			n_checked, n_settings, n_err);
		$display("Outcomes: %0d plain ok, %0d reclaims/rewrites, %0d busy, %0d rejected.",
			n_ok, n_reuse, n_busy, n_reject);
		if (n_err == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
